[design/mlfq_pkg.sv]
// ----------------------------------------------------------------------------
// mlfq_pkg
// Types, codes and helpers shared by the multilevel feedback scheduler.
// ----------------------------------------------------------------------------
package mlfq_pkg;

   localparam int NUM_QUEUES = 4;

   localparam logic CMD_SUBMIT = 1'b0;
   localparam logic CMD_STEP   = 1'b1;

   localparam logic MODE_FCFS  = 1'b0;
   localparam logic MODE_MLFQ  = 1'b1;

   localparam logic [1:0] ST_ACCEPTED = 2'd0;
   localparam logic [1:0] ST_RAN      = 2'd1;
   localparam logic [1:0] ST_IDLE_ALL = 2'd2;
   localparam logic [1:0] ST_FULL     = 2'd3;

   typedef enum logic [1:0] {
      CSR_POLICY_MODE   = 2'd0,
      CSR_QUANTUM_ONE   = 2'd1,
      CSR_QUANTUM_TWO   = 2'd2,
      CSR_QUANTUM_THREE = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      Q_DISPATCH = 2'd0,
      Q_LEVEL1   = 2'd1,
      Q_LEVEL2   = 2'd2,
      Q_LEVEL3   = 2'd3
   } queue_id_type;

   typedef struct packed {
      logic         push_en;
      queue_id_type push_q;
      logic         pop_en;
      queue_id_type pop_q;
   } qop_type;

   typedef struct packed {
      logic [31:0] arrival_time;
      logic [15:0] job_id;
      logic [15:0] run_length;
   } disp_word_type;

   typedef struct packed {
      logic [15:0] job_id;
      logic [15:0] run_length;
      logic [15:0] processed;
   } lvl_word_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] start_time;
      logic [15:0] ran_id;
      logic [1:0]  level;
      logic        completed;
      logic [31:0] end_time;
   } rsp_type;

   function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [15:0] b);
      logic [32:0] sum;
      sum = {1'b0, a} + {17'b0, b};
      return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
   endfunction

endpackage

[design/mlfq_if.sv]
// ----------------------------------------------------------------------------
// mlfq_if
// Request and response channels of the scheduler (valid/ready).
// ----------------------------------------------------------------------------
interface mlfq_req_if;
   logic        valid;
   logic        ready;
   logic        cmd;
   logic [31:0] arrival_time;
   logic [15:0] job_id;
   logic [15:0] run_length;

   modport source (output valid, cmd, arrival_time, job_id, run_length, input ready);
   modport sink   (input valid, cmd, arrival_time, job_id, run_length, output ready);
endinterface

interface mlfq_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [31:0] start_time;
   logic [15:0] ran_id;
   logic [1:0]  level;
   logic        completed;
   logic [31:0] end_time;

   modport source (output valid, status, start_time, ran_id, level, completed, end_time,
                   input ready);
   modport sink   (input valid, status, start_time, ran_id, level, completed, end_time,
                   output ready);
endinterface

[design/mlfq_ram.sv]
// ----------------------------------------------------------------------------
// mlfq_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module mlfq_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[design/mlfq_queues.sv]
// ----------------------------------------------------------------------------
// mlfq_queues
// Head, tail and count registers of the dispatch FIFO and the three levels.
// ----------------------------------------------------------------------------
module mlfq_queues import mlfq_pkg::*; #(
   parameter int MAX_JOBS = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   input  qop_type                          qop,
   output logic [$clog2(MAX_JOBS)-1:0]      heads  [NUM_QUEUES],
   output logic [$clog2(MAX_JOBS)-1:0]      tails  [NUM_QUEUES],
   output logic [$clog2(MAX_JOBS+1)-1:0]    counts [NUM_QUEUES]
);

   localparam int IDX_W = $clog2(MAX_JOBS);
   localparam int CNT_W = $clog2(MAX_JOBS + 1);

   logic [IDX_W-1:0] head_ff  [NUM_QUEUES];
   logic [IDX_W-1:0] tail_ff  [NUM_QUEUES];
   logic [CNT_W-1:0] count_ff [NUM_QUEUES];

   function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] i);
      return (i == IDX_W'(MAX_JOBS - 1)) ? '0 : i + IDX_W'(1);
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_QUEUES; i++) begin
            head_ff[i]  <= '0;
            tail_ff[i]  <= '0;
            count_ff[i] <= '0;
         end
      end else begin
         for (int i = 0; i < NUM_QUEUES; i++) begin
            if (qop.push_en && (qop.push_q == queue_id_type'(i))) begin
               tail_ff[i] <= next_slot(tail_ff[i]);
            end
            if (qop.pop_en && (qop.pop_q == queue_id_type'(i))) begin
               head_ff[i] <= next_slot(head_ff[i]);
            end
            count_ff[i] <= count_ff[i]
                           + CNT_W'(qop.push_en && (qop.push_q == queue_id_type'(i)))
                           - CNT_W'(qop.pop_en && (qop.pop_q == queue_id_type'(i)));
         end
      end
   end

   assign heads  = head_ff;
   assign tails  = tail_ff;
   assign counts = count_ff;

endmodule

[design/multilevel_feedback_scheduler.sv]
// ----------------------------------------------------------------------------
// multilevel_feedback_scheduler
// Job scheduler with FCFS and three-level feedback queue policies.
// ----------------------------------------------------------------------------
// A submit transaction appends a job to the dispatch FIFO unless the store is
// full; its response is valid the cycle after acceptance. A step transaction
// runs one scheduling round: in FCFS mode, and in feedback mode when no job
// runs, the response is registered from S_DISP (one dispatch RAM read); else
// it is registered from S_RUN after S_DISP and S_LREAD (dispatch RAM read and
// any level 1 push, level RAM read, slice update). One transaction is
// processed at a time; a new one is taken in the cycle its predecessor's
// response is consumed. Job storage lives in two synchronous RAMs (MAX_JOBS
// and 3*MAX_JOBS entries) that need no initialization.
// ----------------------------------------------------------------------------
module multilevel_feedback_scheduler import mlfq_pkg::*; #(
   parameter int MAX_JOBS = 64
) (
   input  logic              clock,
   input  logic              reset,
   mlfq_req_if.sink          req_ch,
   mlfq_rsp_if.source        rsp_ch,
   input  logic              csr_write_en,
   input  csr_index_type     csr_index,
   input  logic [15:0]       csr_wdata
);

   localparam int IDX_W  = $clog2(MAX_JOBS);
   localparam int CNT_W  = $clog2(MAX_JOBS + 1);
   localparam int LVL_D  = 3 * MAX_JOBS;
   localparam int LVL_AW = $clog2(LVL_D);

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_DISP  = 4'b0010,
      S_LREAD = 4'b0100,
      S_RUN   = 4'b1000
   } state_type;

   state_type        state_ff, state_in;
   logic             mode_ff;
   logic [15:0]      quantum1_ff, quantum2_ff, quantum3_ff;
   logic [31:0]      time_ff, time_in;
   logic [CNT_W-1:0] live_ff, live_in;
   queue_id_type     qsel_ff, qsel_in;
   rsp_type          rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;

   qop_type          qop;
   logic [IDX_W-1:0] heads  [NUM_QUEUES];
   logic [IDX_W-1:0] tails  [NUM_QUEUES];
   logic [CNT_W-1:0] counts [NUM_QUEUES];

   logic             disp_we;
   disp_word_type    disp_wdata, disp_rdata;
   logic             lvl_we;
   logic [LVL_AW-1:0] lvl_waddr, lvl_raddr;
   lvl_word_type     lvl_wdata, lvl_rdata;

   logic             req_acc;
   logic             levels_empty, move;
   logic [31:0]      fcfs_end;
   queue_id_type     next_q;
   logic [15:0]      quantum;
   logic [16:0]      served;
   logic             finish;
   logic [15:0]      remain;
   logic [31:0]      run_end;

   function automatic logic [LVL_AW-1:0] lvl_addr(input queue_id_type q,
                                                 input logic [IDX_W-1:0] idx);
      logic [LVL_AW-1:0] base;
      base = LVL_AW'(2'(q) - 2'd1) * LVL_AW'(MAX_JOBS);
      return base + LVL_AW'(idx);
   endfunction

   mlfq_queues #(.MAX_JOBS(MAX_JOBS)) u_queues (
      .clock  (clock),
      .reset  (reset),
      .qop    (qop),
      .heads  (heads),
      .tails  (tails),
      .counts (counts)
   );

   mlfq_ram #(.WIDTH($bits(disp_word_type)), .DEPTH(MAX_JOBS)) u_disp_ram (
      .clock   (clock),
      .wr_en   (disp_we),
      .wr_addr (tails[Q_DISPATCH]),
      .wr_data (disp_wdata),
      .rd_addr (heads[Q_DISPATCH]),
      .rd_data (disp_rdata)
   );

   mlfq_ram #(.WIDTH($bits(lvl_word_type)), .DEPTH(LVL_D)) u_lvl_ram (
      .clock   (clock),
      .wr_en   (lvl_we),
      .wr_addr (lvl_waddr),
      .wr_data (lvl_wdata),
      .rd_addr (lvl_raddr),
      .rd_data (lvl_rdata)
   );

   assign req_ch.ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ch.ready);
   assign req_acc      = req_ch.valid && req_ch.ready;

   assign disp_wdata.arrival_time = req_ch.arrival_time;
   assign disp_wdata.job_id       = req_ch.job_id;
   assign disp_wdata.run_length   = req_ch.run_length;

   // dispatch stage
   assign levels_empty = (counts[Q_LEVEL1] == '0) && (counts[Q_LEVEL2] == '0)
                         && (counts[Q_LEVEL3] == '0);
   assign move = (counts[Q_DISPATCH] != '0)
                 && ((disp_rdata.arrival_time <= time_ff) || levels_empty);
   assign fcfs_end = sat_add(time_ff, disp_rdata.run_length);

   // run stage
   assign lvl_raddr = lvl_addr(qsel_ff, heads[qsel_ff]);

   always_comb begin
      case (qsel_ff)
         Q_LEVEL1: quantum = quantum1_ff;
         Q_LEVEL2: quantum = quantum2_ff;
         default:  quantum = quantum3_ff;
      endcase
      case (qsel_ff)
         Q_LEVEL1: next_q = Q_LEVEL2;
         default:  next_q = Q_LEVEL3;
      endcase
   end

   assign served  = {1'b0, lvl_rdata.processed} + {1'b0, quantum};
   assign finish  = served >= {1'b0, lvl_rdata.run_length};
   assign remain  = (lvl_rdata.run_length > lvl_rdata.processed)
                    ? lvl_rdata.run_length - lvl_rdata.processed : 16'd0;
   assign run_end = sat_add(time_ff, finish ? remain : quantum);

   always_comb begin
      state_in     = state_ff;
      time_in      = time_ff;
      live_in      = live_ff;
      qsel_in      = qsel_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      qop          = '0;
      disp_we      = 1'b0;
      lvl_we       = 1'b0;
      lvl_waddr    = lvl_addr(Q_LEVEL1, tails[Q_LEVEL1]);
      lvl_wdata    = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               rsp_in = '0;
               if (req_ch.cmd == CMD_SUBMIT) begin
                  rsp_valid_in = 1'b1;
                  if (live_ff == CNT_W'(MAX_JOBS)) begin
                     rsp_in.status = ST_FULL;
                  end else begin
                     rsp_in.status = ST_ACCEPTED;
                     disp_we       = 1'b1;
                     qop.push_en   = 1'b1;
                     qop.push_q    = Q_DISPATCH;
                     live_in       = live_ff + CNT_W'(1);
                  end
               end else begin
                  state_in = S_DISP;
               end
            end
         end

         S_DISP: begin
            rsp_in.start_time = time_ff;
            rsp_in.end_time   = time_ff;
            rsp_in.status     = ST_IDLE_ALL;
            if (mode_ff == MODE_FCFS) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
               if (counts[Q_DISPATCH] != '0) begin
                  qop.pop_en       = 1'b1;
                  qop.pop_q        = Q_DISPATCH;
                  live_in          = live_ff - CNT_W'(1);
                  time_in          = fcfs_end;
                  rsp_in.status    = ST_RAN;
                  rsp_in.ran_id    = disp_rdata.job_id;
                  rsp_in.completed = 1'b1;
                  rsp_in.end_time  = fcfs_end;
               end
            end else begin
               if (move) begin
                  qop.pop_en   = 1'b1;
                  qop.pop_q    = Q_DISPATCH;
                  qop.push_en  = 1'b1;
                  qop.push_q   = Q_LEVEL1;
                  lvl_we       = 1'b1;
                  lvl_wdata    = '{job_id: disp_rdata.job_id,
                                   run_length: disp_rdata.run_length,
                                   processed: 16'd0};
                  if (disp_rdata.arrival_time > time_ff) begin
                     time_in = disp_rdata.arrival_time;
                  end
               end
               if (move || (counts[Q_LEVEL1] != '0)) begin
                  qsel_in  = Q_LEVEL1;
                  state_in = S_LREAD;
               end else if (counts[Q_LEVEL2] != '0) begin
                  qsel_in  = Q_LEVEL2;
                  state_in = S_LREAD;
               end else if (counts[Q_LEVEL3] != '0) begin
                  qsel_in  = Q_LEVEL3;
                  state_in = S_LREAD;
               end else begin
                  state_in     = S_IDLE;
                  rsp_valid_in = 1'b1;
               end
            end
         end

         S_LREAD: begin
            state_in = S_RUN;
         end

         S_RUN: begin
            state_in          = S_IDLE;
            rsp_valid_in      = 1'b1;
            qop.pop_en        = 1'b1;
            qop.pop_q         = qsel_ff;
            time_in           = run_end;
            rsp_in.status     = ST_RAN;
            rsp_in.start_time = time_ff;
            rsp_in.ran_id     = lvl_rdata.job_id;
            rsp_in.level      = qsel_ff;
            rsp_in.completed  = finish;
            rsp_in.end_time   = run_end;
            if (finish) begin
               live_in = live_ff - CNT_W'(1);
            end else begin
               qop.push_en = 1'b1;
               qop.push_q  = next_q;
               lvl_we      = 1'b1;
               lvl_waddr   = lvl_addr(next_q, tails[next_q]);
               lvl_wdata   = '{job_id: lvl_rdata.job_id,
                               run_length: lvl_rdata.run_length,
                               processed: served[15:0]};
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         time_ff      <= '0;
         live_ff      <= '0;
         qsel_ff      <= Q_LEVEL1;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= MODE_MLFQ;
         quantum1_ff  <= 16'd2;
         quantum2_ff  <= 16'd4;
         quantum3_ff  <= 16'd20;
      end else begin
         state_ff     <= state_in;
         time_ff      <= time_in;
         live_ff      <= live_in;
         qsel_ff      <= qsel_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_en) begin
            unique case (csr_index)
               CSR_POLICY_MODE:   mode_ff     <= csr_wdata[0];
               CSR_QUANTUM_ONE:   quantum1_ff <= csr_wdata;
               CSR_QUANTUM_TWO:   quantum2_ff <= csr_wdata;
               CSR_QUANTUM_THREE: quantum3_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.status     = rsp_ff.status;
   assign rsp_ch.start_time = rsp_ff.start_time;
   assign rsp_ch.ran_id     = rsp_ff.ran_id;
   assign rsp_ch.level      = rsp_ff.level;
   assign rsp_ch.completed  = rsp_ff.completed;
   assign rsp_ch.end_time   = rsp_ff.end_time;

   // every live job sits in exactly one queue
   a_job_count : assert property (@(posedge clock) disable iff (reset)
      ((CNT_W+2)'(counts[0]) + (CNT_W+2)'(counts[1]) + (CNT_W+2)'(counts[2])
       + (CNT_W+2)'(counts[3])) == (CNT_W+2)'(live_ff))
      else $error("queue counts disagree with live job count");

   a_live_bound : assert property (@(posedge clock) disable iff (reset)
      live_ff <= CNT_W'(MAX_JOBS))
      else $error("live job count above capacity");

   a_rsp_idle : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == S_IDLE))
      else $error("response pending while a round is in progress");

   a_step_start : assert property (@(posedge clock) disable iff (reset)
      (req_acc && (req_ch.cmd == CMD_STEP)) |=> (state_ff == S_DISP) && !rsp_valid_ff)
      else $error("step transaction did not enter dispatch stage");

endmodule

[verif/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the multilevel feedback scheduler. Submit and step
// transactions drive the block while a behavioral model of the queues and
// the clock predicts every response, which a monitor compares field by
// field. Directed cases, store overflow, random phases with varied quanta
// and handshake idling, and time saturation run in turn.
// ----------------------------------------------------------------------------
module tb_top;
   import mlfq_pkg::*;

   localparam int JOB_SLOTS = 64;

   typedef struct packed {
      logic        cmd;
      logic [31:0] arrival_time;
      logic [15:0] job_id;
      logic [15:0] run_length;
   } sched_req_type;

   logic          clock;
   logic          reset;
   logic          csr_write_en;
   csr_index_type csr_index;
   logic [15:0]   csr_wdata;

   mlfq_req_if req_ch();
   mlfq_rsp_if rsp_ch();

   multilevel_feedback_scheduler #(.MAX_JOBS(JOB_SLOTS)) dut (
      .clock        (clock),
      .reset        (reset),
      .req_ch       (req_ch),
      .rsp_ch       (rsp_ch),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   // scheduler model state
   logic          sim_mode;
   logic [15:0]   sim_quantum [1:3];
   disp_word_type dispatch_q[$];
   lvl_word_type  level_q[4][$];
   int            live_count;
   logic [31:0]   sim_clock;

   rsp_type pending_slices[$];
   int      error_count;
   int      send_idle_pct;
   int      recv_stall_pct;
   int      hold_request;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #1_000_000;
      $display("tb_top: errors");
      $finish;
   end

   function automatic logic [31:0] time_plus(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
   endfunction

   task automatic predict_slice(input sched_req_type it);
      rsp_type       r;
      disp_word_type dw;
      lvl_word_type  lw;
      logic [1:0]    qsel;
      logic [1:0]    next_q;
      logic [15:0]   quantum;
      logic [16:0]   reach;
      logic [15:0]   rem;
      r = '0;
      if (it.cmd == CMD_SUBMIT) begin
         if (live_count >= JOB_SLOTS) begin
            r.status = ST_FULL;
         end else begin
            dw.arrival_time = it.arrival_time;
            dw.job_id = it.job_id;
            dw.run_length = it.run_length;
            dispatch_q.push_back(dw);
            live_count++;
            r.status = ST_ACCEPTED;
         end
      end else if (sim_mode == MODE_FCFS) begin
         r.start_time = sim_clock;
         if (dispatch_q.size() == 0) begin
            r.status = ST_IDLE_ALL;
         end else begin
            dw = dispatch_q.pop_front();
            live_count--;
            r.status = ST_RAN;
            r.ran_id = dw.job_id;
            r.completed = 1'b1;
            sim_clock = time_plus(sim_clock, {16'b0, dw.run_length});
         end
         r.end_time = sim_clock;
      end else begin
         if (dispatch_q.size() != 0) begin
            dw = dispatch_q[0];
            if (dw.arrival_time <= sim_clock || (level_q[1].size() == 0 &&
                level_q[2].size() == 0 && level_q[3].size() == 0)) begin
               dw = dispatch_q.pop_front();
               if (dw.arrival_time > sim_clock)
                  sim_clock = dw.arrival_time;
               lw.job_id = dw.job_id;
               lw.run_length = dw.run_length;
               lw.processed = 16'd0;
               level_q[1].push_back(lw);
            end
         end
         qsel = 2'd0;
         if (level_q[1].size() != 0)
            qsel = 2'd1;
         else if (level_q[2].size() != 0)
            qsel = 2'd2;
         else if (level_q[3].size() != 0)
            qsel = 2'd3;
         r.start_time = sim_clock;
         if (qsel == 2'd0) begin
            r.status = ST_IDLE_ALL;
         end else begin
            lw = level_q[qsel].pop_front();
            quantum = sim_quantum[qsel];
            r.status = ST_RAN;
            r.ran_id = lw.job_id;
            r.level = qsel;
            reach = {1'b0, lw.processed} + {1'b0, quantum};
            if (reach >= {1'b0, lw.run_length}) begin
               rem = (lw.run_length > lw.processed) ? lw.run_length - lw.processed : 16'd0;
               sim_clock = time_plus(sim_clock, {16'b0, rem});
               r.completed = 1'b1;
               live_count--;
            end else begin
               next_q = (qsel < 2'd3) ? qsel + 2'd1 : 2'd3;
               sim_clock = time_plus(sim_clock, {16'b0, quantum});
               lw.processed = reach[15:0];
               level_q[next_q].push_back(lw);
            end
         end
         r.end_time = sim_clock;
      end
      pending_slices.push_back(r);
   endtask

   task automatic report(input string tag, input rsp_type want, input rsp_type got);
      error_count++;
      if (error_count <= 10)
         $display({"%0t %s: want st=%0d start=%h id=%h lvl=%0d done=%0b end=%h",
                   " | got st=%0d start=%h id=%h lvl=%0d done=%0b end=%h"},
                  $time, tag, want.status, want.start_time, want.ran_id, want.level,
                  want.completed, want.end_time, got.status, got.start_time, got.ran_id,
                  got.level, got.completed, got.end_time);
   endtask

   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         got = {rsp_ch.status, rsp_ch.start_time, rsp_ch.ran_id, rsp_ch.level,
                rsp_ch.completed, rsp_ch.end_time};
         if (pending_slices.size() == 0) begin
            report("unexpected transaction", '0, got);
         end else begin
            want = pending_slices.pop_front();
            if (got.status !== want.status || got.start_time !== want.start_time ||
                got.ran_id !== want.ran_id || got.level !== want.level ||
                got.completed !== want.completed || got.end_time !== want.end_time)
               report("mismatch", want, got);
         end
      end
   end

   // receiver: random stalls plus an optional long hold-off
   initial begin
      int hold_count;
      hold_count = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request > 0) begin
            hold_count = hold_request;
            hold_request = 0;
         end
         if (hold_count > 0) begin
            hold_count--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
         end
      end
   end

   task automatic send_item(input sched_req_type it);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.cmd          <= it.cmd;
      req_ch.arrival_time <= it.arrival_time;
      req_ch.job_id       <= it.job_id;
      req_ch.run_length   <= it.run_length;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      predict_slice(it);
   endtask

   task automatic wait_quiet();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pending_slices.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [15:0] data);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      case (idx)
         CSR_POLICY_MODE:   sim_mode = data[0];
         CSR_QUANTUM_ONE:   sim_quantum[1] = data;
         CSR_QUANTUM_TWO:   sim_quantum[2] = data;
         CSR_QUANTUM_THREE: sim_quantum[3] = data;
         default: ;
      endcase
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic configure(input logic mode, input logic [15:0] q1, input logic [15:0] q2,
                            input logic [15:0] q3);
      wait_quiet();
      write_csr(CSR_POLICY_MODE, {15'b0, mode});
      write_csr(CSR_QUANTUM_ONE, q1);
      write_csr(CSR_QUANTUM_TWO, q2);
      write_csr(CSR_QUANTUM_THREE, q3);
   endtask

   function automatic sched_req_type submit_of(input logic [31:0] arr,
                                               input logic [15:0] id,
                                               input logic [15:0] len);
      sched_req_type it;
      it.cmd = CMD_SUBMIT;
      it.arrival_time = arr;
      it.job_id = id;
      it.run_length = len;
      return it;
   endfunction

   function automatic sched_req_type step_of();
      sched_req_type it;
      it.cmd = CMD_STEP;
      it.arrival_time = $urandom;
      it.job_id = 16'($urandom);
      it.run_length = 16'($urandom);
      return it;
   endfunction

   function automatic sched_req_type random_job();
      sched_req_type it;
      int pick;
      it = step_of();
      it.cmd = 1'($urandom_range(0, 1));
      pick = $urandom_range(0, 9);
      if (pick < 6)
         it.arrival_time = sim_clock + $urandom_range(0, 40);
      else if (pick < 9)
         it.arrival_time = $urandom_range(0, sim_clock);
      else
         it.arrival_time = sim_clock + $urandom_range(0, 2000);
      pick = $urandom_range(0, 99);
      if (pick < 80)
         it.run_length = 16'($urandom_range(0, 40));
      else if (pick < 97)
         it.run_length = 16'($urandom_range(0, 1000));
      return it;
   endfunction

   task automatic drain_all();
      configure(MODE_MLFQ, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      while (live_count != 0) send_item(step_of());
   endtask

   task automatic test_feedback_basics();
      send_item(step_of());
      send_item(submit_of(32'd0, 16'hFFFF, 16'd7));
      send_item(submit_of(32'd1, 16'h0000, 16'd0));
      send_item(submit_of(32'd500, 16'h1234, 16'd3));
      repeat (7) send_item(step_of());
   endtask

   task automatic test_fcfs_mode();
      send_item(submit_of(32'd0, 16'h00AA, 16'd10));
      send_item(step_of());
      configure(MODE_FCFS, 16'd2, 16'd4, 16'd20);
      send_item(submit_of(32'hFFFF_FFFF, 16'h5555, 16'hFFFF));
      send_item(step_of());
      send_item(step_of());
      configure(MODE_MLFQ, 16'd2, 16'd4, 16'd20);
      send_item(step_of());
      send_item(step_of());
   endtask

   task automatic test_zero_quantum();
      configure(MODE_MLFQ, 16'd0, 16'd0, 16'd0);
      send_item(submit_of(sim_clock, 16'h0F0F, 16'd0));
      send_item(submit_of(sim_clock, 16'hF0F0, 16'd5));
      repeat (4) send_item(step_of());
      drain_all();
   endtask

   task automatic test_store_full();
      sched_req_type it;
      configure(MODE_MLFQ, 16'd2, 16'd4, 16'd20);
      send_idle_pct = 10;
      recv_stall_pct = 10;
      repeat (JOB_SLOTS + 2) begin
         it = random_job();
         it.cmd = CMD_SUBMIT;
         send_item(it);
      end
      drain_all();
   endtask

   task automatic test_random_phases();
      int n;
      for (int p = 0; p < 6; p++) begin
         case (p)
            0: begin
               configure(MODE_MLFQ, 16'd2, 16'd4, 16'd20);
               send_idle_pct = 0;
               recv_stall_pct = 0;
            end
            1: begin
               configure(MODE_MLFQ, 16'd1, 16'd1, 16'd1);
               send_idle_pct = 71;
               recv_stall_pct = 0;
            end
            2: begin
               configure(MODE_FCFS, 16'($urandom_range(1, 16)), 16'($urandom_range(1, 16)),
                         16'($urandom_range(1, 16)));
               send_idle_pct = 0;
               recv_stall_pct = 71;
            end
            3: begin
               configure(MODE_MLFQ, 16'hFFFF, 16'hFFFF, 16'hFFFF);
               send_idle_pct = 10;
               recv_stall_pct = 10;
            end
            4: begin
               configure(MODE_MLFQ, 16'($urandom_range(1, 8)), 16'($urandom_range(1, 16)),
                         16'($urandom_range(1, 64)));
               send_idle_pct = 0;
               recv_stall_pct = 0;
            end
            default: begin
               configure(MODE_MLFQ, 16'($urandom_range(1, 32)), 16'($urandom_range(1, 32)),
                         16'($urandom_range(1, 32)));
               send_idle_pct = 71;
               recv_stall_pct = 71;
            end
         endcase
         for (n = 0; n < 140; n++) begin
            send_item(random_job());
            if (p == 4 && n == 20)
               hold_request = 400;
         end
         drain_all();
      end
   endtask

   task automatic test_time_saturation();
      sched_req_type it;
      configure(MODE_MLFQ, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_idle_pct = 10;
      recv_stall_pct = 10;
      send_item(submit_of(32'hFFFF_FFF0, 16'h7E7E, 16'hFFFF));
      send_item(step_of());
      send_item(submit_of(32'd0, 16'h8181, 16'd5));
      send_item(step_of());
      configure(MODE_MLFQ, 16'($urandom_range(1, 8)), 16'($urandom_range(1, 8)),
                16'($urandom_range(1, 8)));
      repeat (40) begin
         it = step_of();
         it.cmd = 1'($urandom_range(0, 1));
         send_item(it);
      end
      configure(MODE_FCFS, 16'd2, 16'd4, 16'd20);
      repeat (20) begin
         it = step_of();
         it.cmd = 1'($urandom_range(0, 1));
         send_item(it);
      end
   endtask

   initial begin
      reset               = 1'b1;
      req_ch.valid        = 1'b0;
      req_ch.cmd          = CMD_SUBMIT;
      req_ch.arrival_time = '0;
      req_ch.job_id       = '0;
      req_ch.run_length   = '0;
      csr_write_en        = 1'b0;
      csr_index           = CSR_POLICY_MODE;
      csr_wdata           = '0;
      sim_mode            = MODE_MLFQ;
      sim_quantum[1]      = 16'd2;
      sim_quantum[2]      = 16'd4;
      sim_quantum[3]      = 16'd20;
      live_count          = 0;
      sim_clock           = '0;
      error_count         = 0;
      send_idle_pct       = 0;
      recv_stall_pct      = 0;
      hold_request        = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_feedback_basics();
      test_fcfs_mode();
      test_zero_quantum();
      test_store_full();
      test_random_phases();
      test_time_saturation();

      wait_quiet();
      repeat (10) @(posedge clock);
      if (error_count == 0)
         $display("tb_top: clean");
      else
         $display("tb_top: errors");
      $finish;
   end

endmodule
